>>> hdl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_BITS  = 32;
   localparam int SLOT_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   // back-word gather tree: one registered OR level over groups of cells
   localparam int GATHER_SPAN   = 8;
   localparam int GATHER_GROUPS = (DEPTH + GATHER_SPAN - 1) / GATHER_SPAN;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_EXEC
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SHIFT_IN,
      OP_SHIFT_OUT,
      OP_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      slot_type    wr_slot;
      slot_type    rd_slot;
      word_type    word;
   } cell_ctrl_type;

   function automatic word_type value_to_word(input logic [31:0] value);
      logic [63:0] ext;
      ext = {{32{value[31]}}, value};
      return ext[WORD_BITS-1:0];
   endfunction

   function automatic logic [31:0] word_to_data(input word_type w);
      logic [63:0] ext;
      ext = {{(64 - WORD_BITS){w[WORD_BITS-1]}}, w};
      return ext[31:0];
   endfunction

endpackage

>>> hdl/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
   input  logic                   clock,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  deq_pkg::slot_type      index,
   input  deq_pkg::word_type      prev_word,
   input  deq_pkg::word_type      next_word,
   output deq_pkg::word_type      word,
   output deq_pkg::word_type      tap
);

   deq_pkg::word_type word_ff;
   deq_pkg::word_type word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         deq_pkg::OP_SHIFT_IN:  word_in = prev_word;
         deq_pkg::OP_SHIFT_OUT: word_in = next_word;
         deq_pkg::OP_WRITE: begin
            if (index == ctrl.wr_slot) begin
               word_in = ctrl.word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign tap  = (index == ctrl.rd_slot) ? word_ff : '0;

endmodule

>>> hdl/deq_gather.sv
`timescale 1ns / 1ps

module deq_gather (
   input  logic              clock,
   input  deq_pkg::word_type taps [deq_pkg::DEPTH],
   output deq_pkg::word_type back_word
);

   deq_pkg::word_type group_ff [deq_pkg::GATHER_GROUPS];
   deq_pkg::word_type group_in [deq_pkg::GATHER_GROUPS];

   always_comb begin
      for (int g = 0; g < deq_pkg::GATHER_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < deq_pkg::GATHER_SPAN; k++) begin
            if (g * deq_pkg::GATHER_SPAN + k < deq_pkg::DEPTH) begin
               group_in[g] = group_in[g] | taps[g * deq_pkg::GATHER_SPAN + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      back_word = '0;
      for (int g = 0; g < deq_pkg::GATHER_GROUPS; g++) begin
         back_word = back_word | group_ff[g];
      end
   end

endmodule

>>> hdl/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed words, held in a row of shift cells
// with the front word always in the first cell. A request is taken when start
// is high and busy is low; busy then stays high through the gather and execute
// states, and the result shows on rsp_* with rsp_valid for one cycle after the
// execute state. The next request may be taken in the cycle the result shows,
// not before: the block first gathers the back word through a registered OR
// tree over the cells, then updates the cells. There is no output buffering:
// the receiver must take each result when it appears. The cells are not cleared
// at reset; only words already pushed are read.
module double_ended_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_data,
   output logic [6:0]  rsp_entries,
   output logic [1:0]  rsp_status
);

   deq_pkg::state_type     state_ff, state_in;
   deq_pkg::count_type     count_ff, count_in;
   logic [2:0]             cmd_ff;
   logic [31:0]            value_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_data_ff, rsp_data_in;
   deq_pkg::status_type    rsp_status_ff, rsp_status_in;
   deq_pkg::count_type     rsp_entries_ff;
   logic                   exec_en;
   logic                   busy_int;
   deq_pkg::cell_op_type   op_sel;
   deq_pkg::cell_ctrl_type ctrl;
   deq_pkg::word_type      words [deq_pkg::DEPTH];
   deq_pkg::word_type      taps  [deq_pkg::DEPTH];
   deq_pkg::word_type      back_word;
   logic                   accept;

   assign accept = start && !busy_int;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         deq_pkg::ST_IDLE:   if (start) state_in = deq_pkg::ST_GATHER;
         deq_pkg::ST_GATHER: state_in = deq_pkg::ST_EXEC;
         deq_pkg::ST_EXEC:   state_in = deq_pkg::ST_IDLE;
         default:            state_in = deq_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy_int = 1'b1;
      exec_en  = 1'b0;
      unique case (state_ff)
         deq_pkg::ST_IDLE:   busy_int = 1'b0;
         deq_pkg::ST_GATHER: busy_int = 1'b1;
         deq_pkg::ST_EXEC:   exec_en  = 1'b1;
         default:            busy_int = 1'b1;
      endcase
   end

   // command execution
   always_comb begin
      count_in      = count_ff;
      op_sel        = deq_pkg::OP_HOLD;
      rsp_data_in   = '0;
      rsp_status_in = deq_pkg::STAT_DONE;
      unique case (deq_pkg::cmd_type'(cmd_ff))
         deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
            if (count_ff == deq_pkg::COUNT_BITS'(deq_pkg::DEPTH)) begin
               rsp_status_in = deq_pkg::STAT_FULL;
            end else begin
               op_sel   = (deq_pkg::cmd_type'(cmd_ff) == deq_pkg::CMD_PUSH_FRONT) ?
                          deq_pkg::OP_SHIFT_IN : deq_pkg::OP_WRITE;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
            if (count_ff == '0) begin
               rsp_status_in = deq_pkg::STAT_EMPTY;
            end else begin
               rsp_data_in = deq_pkg::word_to_data(words[0]);
               if (deq_pkg::cmd_type'(cmd_ff) == deq_pkg::CMD_POP_FRONT) begin
                  op_sel   = deq_pkg::OP_SHIFT_OUT;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
            if (count_ff == '0) begin
               rsp_status_in = deq_pkg::STAT_EMPTY;
            end else begin
               rsp_data_in = deq_pkg::word_to_data(back_word);
               if (deq_pkg::cmd_type'(cmd_ff) == deq_pkg::CMD_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      ctrl.op      = exec_en ? op_sel : deq_pkg::OP_HOLD;
      ctrl.wr_slot = count_ff[deq_pkg::SLOT_BITS-1:0];
      ctrl.rd_slot = deq_pkg::SLOT_BITS'(count_ff - 1'b1);
      ctrl.word    = deq_pkg::value_to_word(value_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= exec_en;
         if (exec_en) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
      if (exec_en) begin
         rsp_data_ff    <= rsp_data_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_entries_ff <= count_in;
      end
   end

   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      deq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .index     (deq_pkg::SLOT_BITS'(i)),
         .prev_word ((i == 0) ? ctrl.word : words[(i == 0) ? 0 : i - 1]),
         .next_word ((i == deq_pkg::DEPTH - 1) ? words[i] :
                     words[(i == deq_pkg::DEPTH - 1) ? i : i + 1]),
         .word      (words[i]),
         .tap       (taps[i])
      );
   end

   deq_gather u_gather (
      .clock     (clock),
      .taps      (taps),
      .back_word (back_word)
   );

   assign busy        = busy_int;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_entries = rsp_entries_ff;
   assign rsp_status  = rsp_status_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("no result three cycles after accepted request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::COUNT_BITS'(deq_pkg::DEPTH))
      else $error("entry count beyond depth");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == deq_pkg::ST_IDLE))
      else $error("result strobe outside idle");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::STAT_FULL) |->
         (rsp_entries == deq_pkg::COUNT_BITS'(deq_pkg::DEPTH) && rsp_data == '0))
      else $error("full status with wrong entries or data");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::STAT_EMPTY) |->
         (rsp_entries == '0 && rsp_data == '0))
      else $error("empty status with wrong entries or data");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !exec_en |=> $stable(count_ff))
      else $error("entry count changed outside execute");

endmodule
